FILE: rtl/rqid_pkg.sv
// Package for the request queue with requester-id take.
// Holds command/status codes and the controller/datapath interface structs.
// No dependencies.
package rqid_pkg;

  localparam int QUEUE_DEPTH_DEF     = 16;
  localparam int REQUESTER_COUNT_DEF = 16;
  localparam int ADDR_W              = 64;
  localparam int DATA_W              = 64;
  localparam int CMD_W               = 2;
  localparam int STATUS_W            = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TAKE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic                load_req;
    logic                push_wr;
    logic                pop_rd;
    logic                pop_fin;
    logic                sweep_init;
    logic                sweep_step;
    logic                sweep_fin;
    logic                res_set;
    logic [STATUS_W-1:0] res_status;
    logic                out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             empty;
    logic             full;
    logic             sweep_done;
  } dp_stat_t;

endpackage

FILE: rtl/rqid_ctrl.sv
// Controller for the request queue: sequences push, pop and take-by-id.
// Drives datapath commands and both handshakes. Depends on rqid_pkg.
module rqid_ctrl import rqid_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_POP_WAIT = 3'd2;
  localparam logic [2:0] S_SWEEP    = 3'd3;
  localparam logic [2:0] S_FINISH   = 3'd4;

  logic [2:0] state, state_next;
  logic       out_vld;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.op)
          CMD_PUSH: begin
            cmd.res_set = 1'b1;
            if (stat.full) begin
              cmd.res_status = STATUS_FULL;
            end else begin
              cmd.push_wr    = 1'b1;
              cmd.res_status = STATUS_OK;
            end
            state_next = S_FINISH;
          end
          CMD_POP: begin
            if (stat.empty) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = STATUS_MISS;
              state_next     = S_FINISH;
            end else begin
              cmd.pop_rd = 1'b1;
              state_next = S_POP_WAIT;
            end
          end
          CMD_TAKE: begin
            cmd.sweep_init = 1'b1;
            state_next     = S_SWEEP;
          end
          default: begin
            cmd.res_set    = 1'b1;
            cmd.res_status = STATUS_OK;
            state_next     = S_FINISH;
          end
        endcase
      end
      S_POP_WAIT: begin
        cmd.pop_fin = 1'b1;
        state_next  = S_FINISH;
      end
      S_SWEEP: begin
        if (stat.sweep_done) begin
          cmd.sweep_fin = 1'b1;
          state_next    = S_FINISH;
        end else begin
          cmd.sweep_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_vld || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      out_vld <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_vld <= 1'b1;
      end else if (!out_stall) begin
        out_vld <= 1'b0;
      end
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = out_vld;

endmodule

FILE: rtl/rqid_dpath.sv
// Datapath for the request queue: circular entry memory, pointers, count,
// compaction sweep for take-by-id and the result register. Depends on rqid_pkg.
module rqid_dpath import rqid_pkg::*; #(
  parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF,
  parameter int REQUESTER_COUNT = REQUESTER_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [CMD_W-1:0]                   cmd_in,
  input  logic [$clog2(REQUESTER_COUNT)-1:0] requester,
  input  logic                               read_flag,
  input  logic [ADDR_W-1:0]                  req_address,
  input  logic [DATA_W-1:0]                  req_data,
  input  dp_cmd_t                            cmd,
  output dp_stat_t                           stat,
  output logic [STATUS_W-1:0]                status,
  output logic [$clog2(REQUESTER_COUNT)-1:0] out_requester,
  output logic                               out_read_flag,
  output logic [ADDR_W-1:0]                  out_address,
  output logic [DATA_W-1:0]                  out_data,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   occupancy
);

  localparam int ID_W    = $clog2(REQUESTER_COUNT);
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W   = ID_W + 1 + ADDR_W + DATA_W;
  localparam int RF_BIT  = ADDR_W + DATA_W;
  localparam int ID_LSB  = RF_BIT + 1;

  logic [ENT_W-1:0]    mem [QUEUE_DEPTH];
  logic [ENT_W-1:0]    rd_q;

  logic [CMD_W-1:0]    req_cmd;
  logic [ENT_W-1:0]    req_ent;

  logic [PTR_W-1:0]    head;
  logic [CNT_W-1:0]    count;
  logic [PTR_W-1:0]    rd_ptr;
  logic [PTR_W-1:0]    wr_ptr;
  logic [CNT_W-1:0]    rd_left;
  logic [CNT_W-1:0]    kept;
  logic                rd_vld;
  logic                hit;

  logic [STATUS_W-1:0] res_status;
  logic [ENT_W-1:0]    res_entry;

  logic [CNT_W:0]      tail_sum;
  logic [CNT_W:0]      tail_wrap;
  logic [PTR_W-1:0]    tail;
  logic                rd_en;
  logic [PTR_W-1:0]    rd_addr;
  logic                keep_rd;
  logic                wr_en;
  logic [PTR_W-1:0]    wr_addr;
  logic [ENT_W-1:0]    wr_data;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign tail_sum  = (CNT_W+1)'(head) + (CNT_W+1)'(count);
  assign tail_wrap = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) ?
                     tail_sum - (CNT_W+1)'(QUEUE_DEPTH) : tail_sum;
  assign tail      = tail_wrap[PTR_W-1:0];

  assign keep_rd = rd_vld && (rd_q[ENT_W-1:ID_LSB] != req_ent[ENT_W-1:ID_LSB]);
  assign rd_en   = cmd.pop_rd || (cmd.sweep_step && (rd_left != '0));
  assign rd_addr = cmd.pop_rd ? head : rd_ptr;
  assign wr_en   = cmd.push_wr || (cmd.sweep_step && keep_rd);
  assign wr_addr = cmd.push_wr ? tail : wr_ptr;
  assign wr_data = cmd.push_wr ? req_ent : rd_q;

  assign stat.op         = req_cmd;
  assign stat.empty      = (count == '0);
  assign stat.full       = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.sweep_done = (rd_left == '0) && !rd_vld;

  // entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      count  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.push_wr) begin
        count <= count + 1'b1;
      end
      if (cmd.pop_fin) begin
        head  <= ptr_inc(head);
        count <= count - 1'b1;
      end
      if (cmd.sweep_fin) begin
        count <= kept;
      end
      if (cmd.sweep_init) begin
        rd_vld <= 1'b0;
      end else if (cmd.sweep_step) begin
        rd_vld <= (rd_left != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_cmd <= cmd_in;
      req_ent <= {requester, read_flag, req_address, req_data};
    end
    if (cmd.sweep_init) begin
      rd_ptr    <= head;
      wr_ptr    <= head;
      rd_left   <= count;
      kept      <= '0;
      hit       <= 1'b0;
      res_entry <= '0;
    end
    if (cmd.sweep_step) begin
      if (rd_left != '0) begin
        rd_ptr  <= ptr_inc(rd_ptr);
        rd_left <= rd_left - 1'b1;
      end
      if (keep_rd) begin
        wr_ptr <= ptr_inc(wr_ptr);
        kept   <= kept + 1'b1;
      end else if (rd_vld && !hit) begin
        hit       <= 1'b1;
        res_entry <= rd_q;
      end
    end
    if (cmd.sweep_fin) begin
      res_status <= hit ? STATUS_OK : STATUS_MISS;
    end
    if (cmd.res_set) begin
      res_status <= cmd.res_status;
      res_entry  <= '0;
    end
    if (cmd.pop_fin) begin
      res_status <= STATUS_OK;
      res_entry  <= rd_q;
    end
    if (cmd.out_load) begin
      status        <= res_status;
      out_requester <= res_entry[ENT_W-1:ID_LSB];
      out_read_flag <= res_entry[RF_BIT];
      out_address   <= res_entry[RF_BIT-1:DATA_W];
      out_data      <= res_entry[DATA_W-1:0];
      occupancy     <= count;
    end
  end

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    cmd.push_wr |=> count == CNT_W'($past(count) + 1'b1))
    else $error("push did not advance count");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_fin |=> count == CNT_W'($past(count) - 1'b1))
    else $error("pop did not reduce count");

  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_step |-> ((CNT_W+1)'(kept) + (CNT_W+1)'(rd_left) + (CNT_W+1)'(rd_vld))
                       <= (CNT_W+1)'(count))
    else $error("sweep write side ran ahead of read side");

  a_sweep_shrink: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_fin |=> count <= $past(count))
    else $error("take grew the queue");

endmodule

FILE: rtl/request_queue_with_id_extract.sv
// Request queue with pop-oldest and take-oldest-by-requester (purging all its entries).
// Push, command code 3 and pop on an empty queue go through decode and finish.
// Pop adds a read wait state before finish. Take adds a compaction sweep over the
// queued entries, one entry per cycle over the single-read-port memory.
// A result held by out_stall delays the next request until it is taken.
// Synchronous active-high reset empties the queue; entry storage is not cleared.
module request_queue_with_id_extract import rqid_pkg::*; #(
  parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF,
  parameter int REQUESTER_COUNT = REQUESTER_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [CMD_W-1:0]                   cmd,
  input  logic [$clog2(REQUESTER_COUNT)-1:0] requester,
  input  logic                               read_flag,
  input  logic [ADDR_W-1:0]                  req_address,
  input  logic [DATA_W-1:0]                  req_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [STATUS_W-1:0]                status,
  output logic [$clog2(REQUESTER_COUNT)-1:0] out_requester,
  output logic                               out_read_flag,
  output logic [ADDR_W-1:0]                  out_address,
  output logic [DATA_W-1:0]                  out_data,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   occupancy
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  rqid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  rqid_dpath #(
    .QUEUE_DEPTH     (QUEUE_DEPTH),
    .REQUESTER_COUNT (REQUESTER_COUNT)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd_in        (cmd),
    .requester     (requester),
    .read_flag     (read_flag),
    .req_address   (req_address),
    .req_data      (req_data),
    .cmd           (dp_cmd),
    .stat          (dp_stat),
    .status        (status),
    .out_requester (out_requester),
    .out_read_flag (out_read_flag),
    .out_address   (out_address),
    .out_data      (out_data),
    .occupancy     (occupancy)
  );

endmodule
